@@ rtl/tbc_pkg.sv @@
package tbc_pkg;

  localparam int CoordW         = 24;
  localparam int WeightW        = 32;
  localparam int WeightFracBits = 16;

  // Edge vectors, their products and the cross products
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int CrossW = ProdW + 1;
  // |cross| < 2 * (2^CoordW - 1)^2 < 2^(2*CoordW+1)
  localparam int MagW   = 2 * CoordW + 1;
  // One quotient bit per divider stage
  localparam int QuotW  = MagW + WeightFracBits;
  localparam int SgnW   = QuotW + 1;
  localparam int SumW   = QuotW + 3;

  localparam int SetupStages  = 4;
  localparam int FinishStages = 3;
  localparam int Latency      = SetupStages + QuotW + FinishStages;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } item_t;

  typedef struct packed {
    logic signed [WeightW-1:0] weight_u;
    logic signed [WeightW-1:0] weight_v;
    logic signed [WeightW-1:0] weight_w;
    logic                      degenerate;
    logic                      saturated;
  } result_t;

  typedef struct packed {
    logic neg_v;
    logic neg_w;
    logic degen;
  } side_t;

  typedef struct packed {
    logic [MagW-1:0]  divisor;
    logic [QuotW-1:0] num_v;
    logic [QuotW-1:0] num_w;
    side_t            side;
  } div_in_t;

  typedef struct packed {
    logic [QuotW-1:0] q_v;
    logic [QuotW-1:0] q_w;
    side_t            side;
  } div_out_t;

endpackage

@@ rtl/tbc_setup.sv @@
module tbc_setup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tbc_pkg::item_t    item_i,
  output logic              valid_o,
  output tbc_pkg::div_in_t  div_o
);
  import tbc_pkg::*;

  typedef struct packed {
    logic signed [DiffW-1:0] e0x, e0y, e1x, e1y, dx, dy;
  } diff_t;

  typedef struct packed {
    logic signed [ProdW-1:0] pa, pb, pc, pd, pe, pf;
  } prod_t;

  typedef struct packed {
    logic signed [CrossW-1:0] den, nv, nw;
  } cross_t;

  function automatic logic signed [DiffW-1:0] sub_ext(input logic signed [CoordW-1:0] a,
                                                      input logic signed [CoordW-1:0] b);
    return $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
  endfunction

  function automatic logic signed [CrossW-1:0] cross_sub(input logic signed [ProdW-1:0] a,
                                                         input logic signed [ProdW-1:0] b);
    return $signed({a[ProdW-1], a}) - $signed({b[ProdW-1], b});
  endfunction

  function automatic logic [MagW-1:0] magnitude(input logic signed [CrossW-1:0] x);
    logic [CrossW-1:0] t;
    t = x[CrossW-1] ? (~x) + 1'b1 : x;
    return t[MagW-1:0];
  endfunction

  logic [SetupStages-1:0] vld_q;
  diff_t   s1_d, s1_q;
  prod_t   s2_d, s2_q;
  cross_t  s3_d, s3_q;
  div_in_t out_d, out_q;

  always_comb begin
    s1_d.e0x = sub_ext(item_i.bx, item_i.ax);
    s1_d.e0y = sub_ext(item_i.by, item_i.ay);
    s1_d.e1x = sub_ext(item_i.cx, item_i.ax);
    s1_d.e1y = sub_ext(item_i.cy, item_i.ay);
    s1_d.dx  = sub_ext(item_i.px, item_i.ax);
    s1_d.dy  = sub_ext(item_i.py, item_i.ay);
  end

  always_comb begin
    s2_d.pa = s1_q.e0x * s1_q.e1y;
    s2_d.pb = s1_q.e1x * s1_q.e0y;
    s2_d.pc = s1_q.dx  * s1_q.e1y;
    s2_d.pd = s1_q.e1x * s1_q.dy;
    s2_d.pe = s1_q.e0x * s1_q.dy;
    s2_d.pf = s1_q.dx  * s1_q.e0y;
  end

  always_comb begin
    s3_d.den = cross_sub(s2_q.pa, s2_q.pb);
    s3_d.nv  = cross_sub(s2_q.pc, s2_q.pd);
    s3_d.nw  = cross_sub(s2_q.pe, s2_q.pf);
  end

  // Scale the numerators by the weight fraction and split off the signs
  always_comb begin
    out_d.divisor    = magnitude(s3_q.den);
    out_d.num_v      = {magnitude(s3_q.nv), {WeightFracBits{1'b0}}};
    out_d.num_w      = {magnitude(s3_q.nw), {WeightFracBits{1'b0}}};
    out_d.side.neg_v = s3_q.nv[CrossW-1] ^ s3_q.den[CrossW-1];
    out_d.side.neg_w = s3_q.nw[CrossW-1] ^ s3_q.den[CrossW-1];
    out_d.side.degen = (s3_q.den == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SetupStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    s3_q  <= s3_d;
    out_q <= out_d;
  end

  assign valid_o = vld_q[SetupStages-1];
  assign div_o   = out_q;

endmodule

@@ rtl/tbc_divider.sv @@
module tbc_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tbc_pkg::div_in_t   div_i,
  output logic               valid_o,
  output tbc_pkg::div_out_t  div_o
);
  import tbc_pkg::*;

  // Numerator bits shift out at the top while quotient bits shift in below
  typedef struct packed {
    logic [MagW-1:0]  rem;
    logic [QuotW-1:0] nq;
  } lane_t;

  typedef struct packed {
    logic [MagW-1:0] divisor;
    lane_t           lane_v;
    lane_t           lane_w;
    side_t           side;
  } stage_t;

  function automatic lane_t div_step(input lane_t l, input logic [MagW-1:0] d);
    logic [MagW:0]   r2;
    logic [MagW+1:0] sub;
    lane_t           o;
    r2    = {l.rem, l.nq[QuotW-1]};
    sub   = {1'b0, r2} - {2'b00, d};
    o.nq  = {l.nq[QuotW-2:0], ~sub[MagW+1]};
    o.rem = sub[MagW+1] ? r2[MagW-1:0] : sub[MagW-1:0];
    return o;
  endfunction

  stage_t           head;
  stage_t           stg_q [QuotW];
  logic [QuotW-1:0] vld_q;

  always_comb begin
    head.divisor     = div_i.divisor;
    head.lane_v.rem  = '0;
    head.lane_v.nq   = div_i.num_v;
    head.lane_w.rem  = '0;
    head.lane_w.nq   = div_i.num_w;
    head.side        = div_i.side;
  end

  for (genvar j = 0; j < QuotW; j++) begin : g_step
    stage_t src;
    stage_t nxt;

    if (j == 0) begin : g_first
      assign src = head;
    end else begin : g_next
      assign src = stg_q[j-1];
    end

    always_comb begin
      nxt        = src;
      nxt.lane_v = div_step(src.lane_v, src.divisor);
      nxt.lane_w = div_step(src.lane_w, src.divisor);
    end

    always_ff @(posedge clk_i) begin
      stg_q[j] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QuotW-2:0], valid_i};
    end
  end

  assign valid_o    = vld_q[QuotW-1];
  assign div_o.q_v  = stg_q[QuotW-1].lane_v.nq;
  assign div_o.q_w  = stg_q[QuotW-1].lane_w.nq;
  assign div_o.side = stg_q[QuotW-1].side;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QuotW-1] && !stg_q[QuotW-1].side.degen |->
      (stg_q[QuotW-1].lane_v.rem < stg_q[QuotW-1].divisor) &&
      (stg_q[QuotW-1].lane_w.rem < stg_q[QuotW-1].divisor))
    else $error("divider remainder not below divisor");
`endif

endmodule

@@ rtl/tbc_finish.sv @@
module tbc_finish (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tbc_pkg::div_out_t  div_i,
  output logic               valid_o,
  output tbc_pkg::result_t   result_o
);
  import tbc_pkg::*;

  localparam logic [SumW-1:0] One = SumW'(1) << WeightFracBits;

  typedef struct packed {
    logic signed [SgnW-1:0] sv, sw;
    logic                   degen;
  } f1_t;

  typedef struct packed {
    logic signed [SumW-1:0] su, sv, sw;
    logic                   degen;
  } f2_t;

  typedef struct packed {
    logic               clip;
    logic [WeightW-1:0] val;
  } sat_t;

  function automatic logic [SgnW-1:0] apply_sign(input logic [QuotW-1:0] q, input logic neg);
    logic [SgnW-1:0] m;
    m = {1'b0, q};
    return neg ? (~m) + 1'b1 : m;
  endfunction

  function automatic logic [SumW-1:0] sext_sum(input logic [SgnW-1:0] x);
    return {{(SumW-SgnW){x[SgnW-1]}}, x};
  endfunction

  function automatic sat_t sat_weight(input logic [SumW-1:0] x);
    sat_t                s;
    logic [SumW-WeightW:0] top;
    top    = x[SumW-1:WeightW-1];
    s.clip = !((&top) || !(|top));
    if (s.clip) begin
      s.val = x[SumW-1] ? {1'b1, {(WeightW-1){1'b0}}} : {1'b0, {(WeightW-1){1'b1}}};
    end else begin
      s.val = x[WeightW-1:0];
    end
    return s;
  endfunction

  logic [FinishStages-1:0] vld_q;
  f1_t     f1_d, f1_q;
  f2_t     f2_d, f2_q;
  result_t res_d, res_q;
  sat_t    sat_u, sat_v, sat_w;

  always_comb begin
    f1_d.sv    = apply_sign(div_i.q_v, div_i.side.neg_v);
    f1_d.sw    = apply_sign(div_i.q_w, div_i.side.neg_w);
    f1_d.degen = div_i.side.degen;
  end

  // u is exact from the truncated v and w, before any clipping
  always_comb begin
    f2_d.sv    = sext_sum(f1_q.sv);
    f2_d.sw    = sext_sum(f1_q.sw);
    f2_d.su    = One - f2_d.sv - f2_d.sw;
    f2_d.degen = f1_q.degen;
  end

  always_comb begin
    sat_u = sat_weight(f2_q.su);
    sat_v = sat_weight(f2_q.sv);
    sat_w = sat_weight(f2_q.sw);
    if (f2_q.degen) begin
      res_d = '0;
      res_d.degenerate = 1'b1;
    end else begin
      res_d.weight_u   = sat_u.val;
      res_d.weight_v   = sat_v.val;
      res_d.weight_w   = sat_w.val;
      res_d.degenerate = 1'b0;
      res_d.saturated  = sat_u.clip | sat_v.clip | sat_w.clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FinishStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q  <= f1_d;
    f2_q  <= f2_d;
    res_q <= res_d;
  end

  assign valid_o  = vld_q[FinishStages-1];
  assign result_o = res_q;

endmodule

@@ rtl/triangle_barycentric_coords.sv @@
// Pipeline: the accepted start beat passes to the result beat on valid_o through
//   4 setup stages, one restoring divider stage per quotient bit and 3 finish stages.
// Throughput: one beat per cycle; busy stays low and the pipeline never stalls.
// Each result is strobed on valid_o for one cycle; the receiver cannot stall.
// Reset: rst_ni clears every valid bit at once; beats in flight are dropped.
module triangle_barycentric_coords (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tbc_pkg::item_t    item_i,
  output logic              valid_o,
  output tbc_pkg::result_t  result_o
);
  import tbc_pkg::*;

  logic     setup_valid;
  div_in_t  setup_div;
  logic     div_valid;
  div_out_t div_res;

  assign busy = 1'b0;

  tbc_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .item_i  (item_i),
    .valid_o (setup_valid),
    .div_o   (setup_div)
  );

  tbc_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (setup_valid),
    .div_i   (setup_div),
    .valid_o (div_valid),
    .div_o   (div_res)
  );

  tbc_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_valid),
    .div_i    (div_res),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

`ifndef SYNTH
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency valid_o)
    else $error("result beat missing after pipeline latency");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.degenerate |->
      (result_o.weight_u == '0) && (result_o.weight_v == '0) &&
      (result_o.weight_w == '0) && !result_o.saturated)
    else $error("degenerate beat with nonzero weights or clip flag");

  a_unity_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !result_o.degenerate && !result_o.saturated |->
      (result_o.weight_u + result_o.weight_v + result_o.weight_w) ==
        WeightW'(1 << WeightFracBits))
    else $error("unclipped weights do not sum to one");
`endif

endmodule
